// ----- rtl/ssbd_pkg.sv -----
// Shared types and constants for the start/stop bit deframer.
// No dependencies; used by every module under rtl/.
package ssbd_pkg;

  localparam int LINE_BITS = 8;
  localparam int DATA_BITS = 8;

  typedef logic [3:0] pos_t;
  typedef logic [3:0] cnt_t;
  typedef logic [7:0] char_t;

  // Bit position codes: hunting for a start bit, first and last data bit.
  localparam pos_t POS_HUNT  = 4'd0;
  localparam pos_t POS_FIRST = 4'd1;
  localparam pos_t POS_LAST  = 4'(DATA_BITS);

  typedef struct packed {
    pos_t  bit_position;
    char_t char_shift;
  } deframe_state_t;

  localparam deframe_state_t STATE_RESET = '{bit_position: POS_HUNT, char_shift: '0};

endpackage

// ----- rtl/start_stop_bit_deframer.sv -----
// Top level of the start/stop bit deframer: input register, deframe core, result register.
// Depends on ssbd_pkg and ssbd_deframe_core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | sink      | in_valid/in_stall  | in_byte[7:0], bit_count[3:0]
//   out     | source    | out_valid/out_stall| char_byte[7:0]
//
// One line byte per cycle while in_stall is low.
// All eight bit steps run in one pass through the deframe core between
// the input register and the result register.
// Synchronous reset puts the deframer in start bit hunt with empty registers.
// A byte that completes no character never waits on out_stall; one that does
// waits only while the result register holds an untaken character.
module start_stop_bit_deframer
  import ssbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  char_t in_byte,
  input  cnt_t  bit_count,
  output logic  out_valid,
  input  logic  out_stall,
  output char_t char_byte
);

  logic           s1_valid;
  char_t          s1_byte;
  cnt_t           s1_count;
  deframe_state_t deframe_state;
  deframe_state_t deframe_state_next;
  logic           produced;
  char_t          core_char;
  logic           s1_go;

  ssbd_deframe_core u_core (
    .line_byte (s1_byte),
    .bit_count (s1_count),
    .state_in  (deframe_state),
    .state_out (deframe_state_next),
    .produced  (produced),
    .char_byte (core_char)
  );

  // advance unless a new character would overwrite one still waiting
  assign s1_go    = s1_valid && (!out_valid || !out_stall || !produced);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      deframe_state <= STATE_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        deframe_state <= deframe_state_next;
      end
      if (s1_go && produced) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= in_byte;
      s1_count <= bit_count;
    end
    if (s1_go && produced) begin
      char_byte <= core_char;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    deframe_state.bit_position <= POS_LAST)
    else $error("bit position out of range");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_zero_count_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_count == '0) |=> $stable(deframe_state))
    else $error("state changed on an empty transaction");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- rtl/ssbd_bit_cell.sv -----
// One line-bit step of the deframer: start bit hunt or data bit collect.
// Depends on ssbd_pkg.
module ssbd_bit_cell
  import ssbd_pkg::*;
(
  input  logic           en,
  input  logic           line_bit,
  input  deframe_state_t state_in,
  output deframe_state_t state_out,
  output logic           done,
  output char_t          char_out
);

  logic hunting;

  assign hunting  = (state_in.bit_position == POS_HUNT) || (state_in.bit_position > POS_LAST);
  assign char_out = {line_bit, state_in.char_shift[7:1]};

  always_comb begin
    state_out = state_in;
    done      = 1'b0;
    if (en) begin
      if (hunting) begin
        // zero bit is the start bit
        if (!line_bit) begin
          state_out.bit_position = POS_FIRST;
          state_out.char_shift   = '0;
        end
      end else begin
        state_out.char_shift = char_out;
        if (state_in.bit_position == POS_LAST) begin
          done                   = 1'b1;
          state_out.bit_position = POS_HUNT;
        end else begin
          state_out.bit_position = state_in.bit_position + POS_FIRST;
        end
      end
    end
  end

endmodule

// ----- rtl/ssbd_deframe_core.sv -----
// Row of eight bit cells that processes one line byte in a single pass.
// Depends on ssbd_pkg and ssbd_bit_cell.
module ssbd_deframe_core
  import ssbd_pkg::*;
(
  input  char_t          line_byte,
  input  cnt_t           bit_count,
  input  deframe_state_t state_in,
  output deframe_state_t state_out,
  output logic           produced,
  output char_t          char_byte
);

  cnt_t           eff_count;
  deframe_state_t chain [LINE_BITS+1];
  logic [LINE_BITS-1:0] done_v;
  char_t          char_v [LINE_BITS];

  // clamp counts above eight
  assign eff_count = (bit_count > cnt_t'(LINE_BITS)) ? cnt_t'(LINE_BITS) : bit_count;
  assign chain[0]  = state_in;

  for (genvar i = 0; i < LINE_BITS; i++) begin : g_cell
    ssbd_bit_cell u_cell (
      .en        (cnt_t'(i) < eff_count),
      .line_bit  (line_byte[LINE_BITS-1-i]),
      .state_in  (chain[i]),
      .state_out (chain[i+1]),
      .done      (done_v[i]),
      .char_out  (char_v[i])
    );
  end

  assign state_out = chain[LINE_BITS];
  assign produced  = |done_v;

  // at most one cell completes a character per byte
  always_comb begin
    char_byte = '0;
    for (int i = 0; i < LINE_BITS; i++) begin
      if (done_v[i]) begin
        char_byte = char_byte | char_v[i];
      end
    end
  end

endmodule
